FILE: rtl/h2r_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and segment codes of the HSL to RGB converter.
package h2r_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int HUE_W      = 16;
  localparam int VAL_W      = FRAC_BITS + 1;
  localparam int SIX_W      = FRAC_BITS + 3;
  localparam int PIPE_DEPTH = 5;

  localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VAL_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};
  localparam logic [SIX_W-1:0] FOUR_ONE = {3'b100, {FRAC_BITS{1'b0}}};

  localparam logic [FRAC_BITS-1:0] THIRD_TURN =
    FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd3);
  localparam logic [FRAC_BITS-1:0] TWO_THIRD_TURN =
    FRAC_BITS'((64'd1 << FRAC_BITS) - (64'd1 << FRAC_BITS) / 64'd3);
  localparam logic [FRAC_BITS-1:0] ZERO_TURN = '0;
  localparam logic [VAL_W-1:0] GRAY_EPS =
    VAL_W'(((64'd1 << FRAC_BITS) + 64'd99999) / 64'd100000);

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } h2r_seg_e;

  typedef struct packed {
    logic             gray;
    logic [VAL_W-1:0] l;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] d;
  } h2r_levels_t;

endpackage

FILE: rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// Top level of the HSL to RGB converter: transfer control and three channel lanes.
//
// Accepts one pixel on every clock cycle (busy stays low) and returns its red, green
// and blue values through five register stages, marked by done_o for one cycle.
// The stages are clamp, level multiply, level select, channel multiply and channel
// select. Hue is a 16-bit fraction of a turn, saturation and lightness are 1.16
// fixed point and are clamped to 1.0; zero saturation gives gray. The receiver
// cannot stall, so results must be taken when done_o is high.
module hsl_to_rgb_converter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [h2r_pkg::HUE_W-1:0]  hue_i,
  input  logic [h2r_pkg::VAL_W-1:0]  saturation_i,
  input  logic [h2r_pkg::VAL_W-1:0]  lightness_i,
  output logic                       done_o,
  output logic [h2r_pkg::VAL_W-1:0]  red_o,
  output logic [h2r_pkg::VAL_W-1:0]  green_o,
  output logic [h2r_pkg::VAL_W-1:0]  blue_o
);

  logic [h2r_pkg::PIPE_DEPTH-1:0] valid_d, valid_q;
  h2r_pkg::h2r_levels_t           levels;

  assign busy    = 1'b0;
  assign valid_d = {valid_q[h2r_pkg::PIPE_DEPTH-2:0], start & ~busy};
  assign done_o  = valid_q[h2r_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  h2r_levels u_levels (
    .clk_i        (clk_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .levels_o     (levels)
  );

  h2r_channel u_red (
    .clk_i     (clk_i),
    .hue_i     (hue_i),
    .offset_i  (h2r_pkg::THIRD_TURN),
    .levels_i  (levels),
    .channel_o (red_o)
  );

  h2r_channel u_green (
    .clk_i     (clk_i),
    .hue_i     (hue_i),
    .offset_i  (h2r_pkg::ZERO_TURN),
    .levels_i  (levels),
    .channel_o (green_o)
  );

  h2r_channel u_blue (
    .clk_i     (clk_i),
    .hue_i     (hue_i),
    .offset_i  (h2r_pkg::TWO_THIRD_TURN),
    .levels_i  (levels),
    .channel_o (blue_o)
  );

  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(h2r_pkg::PIPE_DEPTH) done_o)
    else $error("transfer did not produce a result");

  a_done_has_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, h2r_pkg::PIPE_DEPTH))
    else $error("result without a transfer");

  a_gray_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && saturation_i == '0)
      |-> ##(h2r_pkg::PIPE_DEPTH) (red_o == green_o && green_o == blue_o))
    else $error("gray pixel gave unequal channels");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (red_o <= h2r_pkg::ONE && green_o <= h2r_pkg::ONE
                && blue_o <= h2r_pkg::ONE))
    else $error("channel above full scale");

endmodule

FILE: rtl/h2r_levels.sv
`timescale 1ns / 1ps
// Three-stage pipeline that derives the high and low levels from saturation and lightness.
module h2r_levels (
  input  logic                         clk_i,
  input  logic [h2r_pkg::VAL_W-1:0]    saturation_i,
  input  logic [h2r_pkg::VAL_W-1:0]    lightness_i,
  output h2r_pkg::h2r_levels_t         levels_o
);

  localparam int PROD_W = 2 * h2r_pkg::VAL_W + 1;

  logic [h2r_pkg::VAL_W-1:0] s_a_d, l_a_d, s_a_q, l_a_q;
  logic                      low_a_d, gray_a_d, low_a_q, gray_a_q;

  logic [h2r_pkg::VAL_W:0]   mult_op;
  logic [PROD_W-1:0]         prod_b_d, prod_b_q;
  logic [h2r_pkg::VAL_W-1:0] s_b_q, l_b_q;
  logic                      low_b_q, gray_b_q;

  logic [h2r_pkg::VAL_W:0]   p_c, sum_c;
  logic [h2r_pkg::VAL_W-1:0] hi_c, e_c;
  h2r_pkg::h2r_levels_t      levels_d, levels_q;

  always_comb begin
    s_a_d    = (saturation_i > h2r_pkg::ONE) ? h2r_pkg::ONE : saturation_i;
    l_a_d    = (lightness_i > h2r_pkg::ONE) ? h2r_pkg::ONE : lightness_i;
    low_a_d  = (l_a_d < h2r_pkg::HALF);
    gray_a_d = (s_a_d < h2r_pkg::GRAY_EPS);
  end

  always_ff @(posedge clk_i) begin
    s_a_q    <= s_a_d;
    l_a_q    <= l_a_d;
    low_a_q  <= low_a_d;
    gray_a_q <= gray_a_d;
  end

  always_comb begin
    mult_op  = low_a_q ? ({1'b0, s_a_q} + {1'b0, h2r_pkg::ONE}) : {1'b0, s_a_q};
    prod_b_d = PROD_W'(l_a_q) * PROD_W'(mult_op);
  end

  always_ff @(posedge clk_i) begin
    prod_b_q <= prod_b_d;
    s_b_q    <= s_a_q;
    l_b_q    <= l_a_q;
    low_b_q  <= low_a_q;
    gray_b_q <= gray_a_q;
  end

  always_comb begin
    p_c   = prod_b_q[h2r_pkg::FRAC_BITS +: h2r_pkg::VAL_W + 1];
    sum_c = {1'b0, l_b_q} + {1'b0, s_b_q} - p_c;
    hi_c  = low_b_q ? p_c[h2r_pkg::VAL_W-1:0] : sum_c[h2r_pkg::VAL_W-1:0];
    e_c   = hi_c - l_b_q;
    levels_d.gray = gray_b_q;
    levels_d.l    = l_b_q;
    levels_d.hi   = hi_c;
    levels_d.lo   = l_b_q - e_c;
    levels_d.d    = {e_c[h2r_pkg::VAL_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    levels_q <= levels_d;
  end

  assign levels_o = levels_q;

endmodule

FILE: rtl/h2r_channel.sv
`timescale 1ns / 1ps
// Five-stage lane that applies the piecewise-linear hue rule to one color channel.
module h2r_channel (
  input  logic                          clk_i,
  input  logic [h2r_pkg::HUE_W-1:0]     hue_i,
  input  logic [h2r_pkg::FRAC_BITS-1:0] offset_i,
  input  h2r_pkg::h2r_levels_t          levels_i,
  output logic [h2r_pkg::VAL_W-1:0]     channel_o
);

  localparam int MUL_W = 2 * h2r_pkg::VAL_W;

  logic [h2r_pkg::FRAC_BITS-1:0] x_a_q;

  logic [h2r_pkg::SIX_W-1:0]     six_b;
  h2r_pkg::h2r_seg_e             seg_b_d, seg_b_q, seg_c_q, seg_d_q;
  logic [h2r_pkg::VAL_W-1:0]     fac_b_d, fac_b_q, fac_c_q;

  logic [MUL_W-1:0]              prod_d_d, prod_d_q;
  h2r_pkg::h2r_levels_t          lv_d_q;

  logic [h2r_pkg::VAL_W-1:0]     ramp_e, chan_d, chan_q;

  always_ff @(posedge clk_i) begin
    x_a_q <= hue_i[h2r_pkg::FRAC_BITS-1:0] + offset_i;
  end

  always_comb begin
    six_b = (h2r_pkg::SIX_W'(x_a_q) << 2) + (h2r_pkg::SIX_W'(x_a_q) << 1);
    if (six_b < h2r_pkg::SIX_W'(h2r_pkg::ONE)) begin
      seg_b_d = h2r_pkg::SEG_RISE;
    end else if (!x_a_q[h2r_pkg::FRAC_BITS-1]) begin
      seg_b_d = h2r_pkg::SEG_HIGH;
    end else if (six_b < h2r_pkg::FOUR_ONE) begin
      seg_b_d = h2r_pkg::SEG_FALL;
    end else begin
      seg_b_d = h2r_pkg::SEG_LOW;
    end
    if (seg_b_d == h2r_pkg::SEG_RISE) begin
      fac_b_d = six_b[h2r_pkg::VAL_W-1:0];
    end else begin
      fac_b_d = h2r_pkg::VAL_W'(h2r_pkg::FOUR_ONE - six_b);
    end
  end

  always_ff @(posedge clk_i) begin
    seg_b_q <= seg_b_d;
    fac_b_q <= fac_b_d;
    seg_c_q <= seg_b_q;
    fac_c_q <= fac_b_q;
  end

  assign prod_d_d = MUL_W'(levels_i.d) * MUL_W'(fac_c_q);

  always_ff @(posedge clk_i) begin
    prod_d_q <= prod_d_d;
    seg_d_q  <= seg_c_q;
    lv_d_q   <= levels_i;
  end

  always_comb begin
    ramp_e = h2r_pkg::VAL_W'({1'b0, lv_d_q.lo}
                             + prod_d_q[h2r_pkg::FRAC_BITS +: h2r_pkg::VAL_W + 1]);
    case (seg_d_q)
      h2r_pkg::SEG_RISE: chan_d = ramp_e;
      h2r_pkg::SEG_HIGH: chan_d = lv_d_q.hi;
      h2r_pkg::SEG_FALL: chan_d = ramp_e;
      h2r_pkg::SEG_LOW:  chan_d = lv_d_q.lo;
      default:           chan_d = lv_d_q.lo;
    endcase
    if (lv_d_q.gray) begin
      chan_d = lv_d_q.l;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
  end

  assign channel_o = chan_q;

endmodule
